// File: rtl/srm_pkg.sv
package srm_pkg;

   // Field and register widths.
   localparam int unsigned SAMPLE_W    = 16;
   localparam int unsigned LEVEL_W     = 16;
   localparam int unsigned CSR_W       = 21;
   localparam logic [CSR_W-1:0] SEGMENT_LENGTH_RESET = 21'd44100;

   // Largest segment the accumulator is sized for.
   localparam int unsigned MAX_SEGMENT = 1048576;

   // A square of a Q15 sample is at most 2^30, so it and the mean fit 31 bits.
   localparam int unsigned SQUARE_W    = 31;
   localparam int unsigned MEAN_W      = 31;

   // Square root unit: 32-bit radicand, 16-bit root, 17-bit partial remainder.
   localparam int unsigned ROOT_W      = 16;
   localparam int unsigned RADICAND_W  = 2 * ROOT_W;
   localparam int unsigned SQ_REM_W    = ROOT_W + 1;

   // Queue between the accumulator and the divide/root unit.
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QLVL_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic              empty;
      logic [QLVL_W-1:0] level;
   } q_stat_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_SQRT,
      ST_DONE
   } back_state_type;

endpackage

// File: rtl/srm_if.sv
interface srm_req_if;
   import srm_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       track_start;

   modport source (output valid, output sample, output track_start, input ready);
   modport sink   (input valid, input sample, input track_start, output ready);
endinterface

interface srm_rsp_if;
   import srm_pkg::*;

   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] rms_level;

   modport source (output valid, output rms_level, input ready);
   modport sink   (input valid, input rms_level, output ready);
endinterface

// File: rtl/srm_queue.sv
module srm_queue #(
   parameter int unsigned DataW = 72
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic [DataW-1:0]   push_data,
   input  logic               pop,
   output logic [DataW-1:0]   pop_data,
   output srm_pkg::q_stat_type stat
);
   import srm_pkg::*;

   logic [DataW-1:0]  entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QLVL_W-1:0] level_ff, level_in;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] ptr);
      logic [QPTR_W-1:0] result;
      if (ptr == QPTR_W'(QUEUE_DEPTH - 1)) begin
         result = '0;
      end else begin
         result = ptr + 1'b1;
      end
      return result;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      level_in  = level_ff;
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data   = entry_ff[rd_ptr_ff];
   assign stat.level = level_ff;
   assign stat.empty = (level_ff == '0);

endmodule

// File: rtl/srm_front.sv
module srm_front #(
   parameter int unsigned MaxSegment = srm_pkg::MAX_SEGMENT,
   parameter int unsigned CntW       = $clog2(MaxSegment + 1),
   parameter int unsigned SumW       = CntW + 30
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [srm_pkg::CSR_W-1:0] csr_wdata,
   srm_req_if.sink                   req_if,
   input  srm_pkg::q_stat_type       q_stat,
   output logic                      push,
   output logic [SumW+CntW-1:0]      push_data
);
   import srm_pkg::*;

   logic [CSR_W-1:0]    length_ff;
   logic [CntW-1:0]     length_eff;

   // Squaring stage.
   logic                s1_valid_ff;
   logic [SQUARE_W-1:0] s1_square_ff;
   logic                s1_clear_ff;
   logic signed [2*SAMPLE_W-1:0] product;

   // Accumulating stage.
   logic [SumW-1:0]     sum_ff, sum_in, sum_base, sum_next;
   logic [CntW-1:0]     count_ff, count_in, count_base, count_next;
   logic                accept;
   logic                close;

   assign accept = req_if.valid && req_if.ready;

   // A sample in the squaring stage may still close a segment, so it holds
   // a queue slot in reserve.
   assign req_if.ready = ((QLVL_W + 1)'(q_stat.level) + (QLVL_W + 1)'(s1_valid_ff))
                         < (QLVL_W + 1)'(QUEUE_DEPTH);

   assign product = req_if.sample * req_if.sample;

   always_comb begin
      if (length_ff == '0) begin
         length_eff = CntW'(1);
      end else if (length_ff > CSR_W'(MaxSegment)) begin
         length_eff = CntW'(MaxSegment);
      end else begin
         length_eff = CntW'(length_ff);
      end
   end

   always_comb begin
      sum_base   = s1_clear_ff ? '0 : sum_ff;
      count_base = s1_clear_ff ? '0 : count_ff;
      sum_next   = sum_base + SumW'(s1_square_ff);
      count_next = count_base + 1'b1;
      close      = s1_valid_ff && (count_next >= length_eff);
      push       = close;
      push_data  = {sum_next, count_next};
      sum_in     = sum_ff;
      count_in   = count_ff;
      if (close) begin
         sum_in   = '0;
         count_in = '0;
      end else if (s1_valid_ff) begin
         sum_in   = sum_next;
         count_in = count_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff   <= SEGMENT_LENGTH_RESET;
         s1_valid_ff <= 1'b0;
         sum_ff      <= '0;
         count_ff    <= '0;
      end else begin
         if (csr_we) begin
            length_ff <= csr_wdata;
         end
         s1_valid_ff <= accept;
         sum_ff      <= sum_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_square_ff <= SQUARE_W'(product);
         s1_clear_ff  <= req_if.track_start;
      end
   end

endmodule

// File: rtl/srm_back.sv
module srm_back #(
   parameter int unsigned MaxSegment = srm_pkg::MAX_SEGMENT,
   parameter int unsigned CntW       = $clog2(MaxSegment + 1),
   parameter int unsigned SumW       = CntW + 30
) (
   input  logic                 clock,
   input  logic                 reset,
   input  srm_pkg::q_stat_type  q_stat,
   input  logic [SumW+CntW-1:0] pop_data,
   output logic                 pop,
   srm_rsp_if.source            rsp_if
);
   import srm_pkg::*;

   localparam int unsigned StepW = $clog2(SumW);

   back_state_type state_ff, state_in;

   logic [StepW-1:0] step_ff, step_in;
   logic             last_step;
   logic             div_step;
   logic             sqrt_step;
   logic             out_load;

   // Restoring divider: quotient bits shift into the dividend register.
   logic [SumW-1:0]  quo_ff, quo_in;
   logic [CntW-1:0]  divisor_ff;
   logic [CntW-1:0]  rem_ff, rem_in;
   logic [CntW:0]    rem_shift;

   // Digit-by-digit square root, two radicand bits per step.
   logic [RADICAND_W-1:0] rad_ff, rad_in;
   logic [SQ_REM_W-1:0]   sq_rem_ff, sq_rem_in;
   logic [ROOT_W-1:0]     root_ff, root_in;
   logic [SQ_REM_W+1:0]   sq_shift;
   logic [ROOT_W+1:0]     trial;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0] rsp_level_ff;

   assign last_step = (step_ff == '0);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (!q_stat.empty) state_in = ST_DIV;
         ST_DIV:  if (last_step) state_in = ST_SQRT;
         ST_SQRT: if (last_step) state_in = ST_DONE;
         ST_DONE: if (!rsp_valid_ff || rsp_if.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pop       = 1'b0;
      div_step  = 1'b0;
      sqrt_step = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         ST_IDLE: pop       = !q_stat.empty;
         ST_DIV:  div_step  = 1'b1;
         ST_SQRT: sqrt_step = 1'b1;
         ST_DONE: out_load  = !rsp_valid_ff || rsp_if.ready;
         default: pop       = 1'b0;
      endcase
   end

   always_comb begin
      rem_shift = {rem_ff, quo_ff[SumW-1]};
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      if (rem_shift >= {1'b0, divisor_ff}) begin
         rem_in = CntW'(rem_shift - {1'b0, divisor_ff});
         quo_in = {quo_ff[SumW-2:0], 1'b1};
      end else begin
         rem_in = CntW'(rem_shift);
         quo_in = {quo_ff[SumW-2:0], 1'b0};
      end
   end

   always_comb begin
      sq_shift  = {sq_rem_ff, rad_ff[RADICAND_W-1 -: 2]};
      trial     = {root_ff, 2'b01};
      rad_in    = {rad_ff[RADICAND_W-3:0], 2'b00};
      if (sq_shift >= {1'b0, trial}) begin
         sq_rem_in = SQ_REM_W'(sq_shift - {1'b0, trial});
         root_in   = {root_ff[ROOT_W-2:0], 1'b1};
      end else begin
         sq_rem_in = SQ_REM_W'(sq_shift);
         root_in   = {root_ff[ROOT_W-2:0], 1'b0};
      end
   end

   always_comb begin
      step_in = step_ff;
      if (pop) begin
         step_in = StepW'(SumW - 1);
      end else if (div_step && last_step) begin
         step_in = StepW'(ROOT_W - 1);
      end else if (div_step || sqrt_step) begin
         step_in = step_ff - 1'b1;
      end
      rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      if (pop) begin
         quo_ff     <= pop_data[SumW+CntW-1:CntW];
         divisor_ff <= pop_data[CntW-1:0];
         rem_ff     <= '0;
      end else if (div_step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
      if (div_step && last_step) begin
         // The mean is at most 2^30, so the upper quotient bits are zero.
         rad_ff    <= RADICAND_W'(quo_in[MEAN_W-1:0]);
         sq_rem_ff <= '0;
         root_ff   <= '0;
      end else if (sqrt_step) begin
         rad_ff    <= rad_in;
         sq_rem_ff <= sq_rem_in;
         root_ff   <= root_in;
      end
      if (out_load) begin
         rsp_level_ff <= root_ff;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.rms_level = rsp_level_ff;

endmodule

// File: rtl/segment_rms_meter_top.sv
// Segment RMS level meter. Signed Q15 mono samples arrive on the req_if channel
// and are cut into back-to-back segments of segment_length samples (written
// through csr_we/csr_wdata; a length of zero acts as one, a length above
// MaxSegment acts as MaxSegment, and a new length applies to the running
// segment at once). A sample with track_start set discards the partial segment
// before it is counted. When a segment fills, one transfer on rsp_if carries
// rms_level = floor(sqrt(floor(sum of squares / samples))), a Q15 magnitude
// from 0 to 32768; a trailing partial segment produces nothing. The front end
// squares and accumulates one sample per cycle while req_if.ready is high. Each
// closed segment is handed through a two-entry queue to the back end, which
// takes one at a time: it picks it up, divides bit-serially over SumW quotient
// bits (SumW = 51 at the default MaxSegment), takes a 16-bit square root and
// delivers the result. While a closed segment sits in the queue, a sample in
// the squaring stage reserves the other slot, so req_if.ready is low whenever
// a sample is in that stage; if the back end is idle, this lasts only until it
// picks the segment up. If segments close faster than the back end finishes
// them, the queue fills and req_if.ready stays low until the back end catches
// up. The result register lets the back end finish the next segment while a
// result waits for rsp_if.ready. No initialization sweep is needed after reset.
module segment_rms_meter_top #(
   parameter int unsigned MaxSegment = srm_pkg::MAX_SEGMENT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [srm_pkg::CSR_W-1:0] csr_wdata,
   srm_req_if.sink                   req_if,
   srm_rsp_if.source                 rsp_if
);
   import srm_pkg::*;

   // Sample count and sum of squares widths follow from the longest segment.
   localparam int unsigned CntW = $clog2(MaxSegment + 1);
   localparam int unsigned SumW = CntW + 30;

   q_stat_type            q_stat;
   logic                  q_push;
   logic                  q_pop;
   logic [SumW+CntW-1:0]  q_push_data;
   logic [SumW+CntW-1:0]  q_pop_data;

   // Front end: length register, squaring stage and segment accumulator.
   srm_front #(
      .MaxSegment (MaxSegment),
      .CntW       (CntW),
      .SumW       (SumW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_if    (req_if),
      .q_stat    (q_stat),
      .push      (q_push),
      .push_data (q_push_data)
   );

   // Closed segments (sum of squares, sample count) wait here.
   srm_queue #(
      .DataW (SumW + CntW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .stat      (q_stat)
   );

   // Back end: divide by the count, take the square root, hold the result.
   srm_back #(
      .MaxSegment (MaxSegment),
      .CntW       (CntW),
      .SumW       (SumW)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_stat   (q_stat),
      .pop_data (q_pop_data),
      .pop      (q_pop),
      .rsp_if   (rsp_if)
   );

   // The front end reserves queue space, so a closing segment always finds room.
   assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_stat.level < QLVL_W'(QUEUE_DEPTH)))
      else $error("segment queue overflow");

   // The back end only picks up a segment that is there.
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("segment queue read while empty");

   // The RMS of Q15 samples never exceeds full scale.
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.rms_level <= LEVEL_W'(32768)))
      else $error("rms level above full scale");

endmodule
